// ----- design/tecf_pkg.sv -----
// Shared constants and types of the track edge and center finder.
`timescale 1ns / 1ps
package tecf_pkg;

    // Parameter defaults
    localparam int DEF_ROW_PIXELS = 80;
    localparam int DEF_FRAME_ROWS = 60;
    localparam int DEF_GROUP_ROWS = 5;
    localparam int DEF_RUN_LENGTH = 8;

    // Fixed widths
    localparam int LANES    = 8;    // pixels per packed byte
    localparam int EDGE_W   = 8;
    localparam int RUN_W    = 4;    // holds a run length up to 15
    localparam int ROWNUM_W = 6;
    localparam int WIDTH_W  = 7;
    localparam int MEAN_W   = 12;
    localparam int AREA_W   = 13;
    localparam int TURN_W   = 6;

    localparam logic [EDGE_W-1:0] NO_EDGE    = 8'd255;
    localparam logic [MEAN_W-1:0] EMPTY_MEAN = 12'd4080;

    typedef struct packed {
        logic             hit;   // a full white run ends on this pixel
        logic [RUN_W-1:0] run;   // saturated run length ending on this pixel
    } lane_res_t;

    typedef struct packed {
        logic              first_found;
        logic [EDGE_W-1:0] first_left;
        logic [EDGE_W-1:0] last_right;
        logic [RUN_W-1:0]  white_run;
    } scan_t;

    localparam scan_t SCAN_CLEAR = '{
        first_found: 1'b0,
        first_left:  '0,
        last_right:  NO_EDGE,
        white_run:   '0
    };

endpackage

// ----- design/tecf_lane.sv -----
// One pixel lane: run length and run-end detection for one bit of the byte.
`timescale 1ns / 1ps
module tecf_lane #(
    parameter int LANE       = 0,
    parameter int ROW_PIXELS = tecf_pkg::DEF_ROW_PIXELS,
    parameter int RUN_LENGTH = tecf_pkg::DEF_RUN_LENGTH,
    parameter int BP_W       = 4
) (
    input  logic [tecf_pkg::LANES-1:0] white,     // bit k: pixel k of the byte is white
    input  logic [BP_W-1:0]            byte_pos,
    input  logic [tecf_pkg::RUN_W-1:0] run_in,    // run carried in from earlier bytes
    output tecf_pkg::lane_res_t        res
);
    import tecf_pkg::*;

    logic [3:0]      cnt;
    logic            chain;
    logic [4:0]      total;
    logic [BP_W+2:0] col;
    logic            valid;

    always_comb begin
        cnt   = '0;
        chain = 1'b1;
        // count white pixels back from this lane toward the byte start
        for (int k = LANE; k >= 0; k--) begin
            if (chain && white[k]) begin
                cnt = cnt + 4'd1;
            end else begin
                chain = 1'b0;
            end
        end
        total = chain ? (5'(run_in) + 5'(cnt)) : 5'(cnt);
        col   = {byte_pos, 3'(LANE)};
        valid = (32'(col) < 32'(ROW_PIXELS));
        res.hit = valid && (total >= 5'(RUN_LENGTH));
        res.run = (total >= 5'(RUN_LENGTH)) ? RUN_W'(RUN_LENGTH) : RUN_W'(total);
    end

endmodule

// ----- design/tecf_merge.sv -----
// Merge of the lane results into the row scan state.
`timescale 1ns / 1ps
module tecf_merge #(
    parameter int RUN_LENGTH = tecf_pkg::DEF_RUN_LENGTH,
    parameter int BP_W       = 4
) (
    input  tecf_pkg::lane_res_t lane_res [tecf_pkg::LANES],
    input  logic [BP_W-1:0]     byte_pos,
    input  tecf_pkg::scan_t     scan_in,
    output tecf_pkg::scan_t     scan_out
);
    import tecf_pkg::*;

    logic       any_hit;
    logic [2:0] first_idx;
    logic [2:0] last_idx;

    always_comb begin
        any_hit   = 1'b0;
        first_idx = '0;
        last_idx  = '0;
        for (int b = LANES - 1; b >= 0; b--) begin
            if (lane_res[b].hit) begin
                first_idx = 3'(b);
            end
        end
        for (int b = 0; b < LANES; b++) begin
            if (lane_res[b].hit) begin
                last_idx = 3'(b);
                any_hit  = 1'b1;
            end
        end

        scan_out           = scan_in;
        scan_out.white_run = lane_res[LANES-1].run;
        if (any_hit) begin
            scan_out.last_right = EDGE_W'({byte_pos, last_idx});
            if (!scan_in.first_found) begin
                scan_out.first_found = 1'b1;
                scan_out.first_left  = EDGE_W'({byte_pos, first_idx})
                                     - EDGE_W'(RUN_LENGTH - 1);
            end
        end
    end

endmodule

// ----- design/tecf_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tecf_div #(
    parameter int DW = 16,   // dividend and quotient width
    parameter int VW = 3     // divisor width
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    import tecf_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   trial;
    logic          ge;
    logic [VW-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DW-1]};
        ge       = (trial >= {1'b0, div_reg});
        rem_next = ge ? VW'(trial - {1'b0, div_reg}) : VW'(trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/track_edge_and_center_finder_top.sv -----
// Top level of the track edge and center finder.
`timescale 1ns / 1ps
//
//  channel   direction  handshake             payload
//  s_        in         s_tvalid / s_tready   s_tdata pixel byte, s_tuser frame start
//  m_        out        m_tvalid / m_tready   m_tdata row results, m_tuser group done,
//                                             m_tlast frame done
//  cfg_      in         cfg_valid / cfg_ready cfg_data white code
//
//  One pixel byte per cycle while s_tready is high. The byte that ends a row is taken only when the
//  output register is free or being emptied in that cycle. A row that closes a
//  group with valid rows holds the input while the serial divider (DW = group
//  sum width + 4) forms the group mean, one quotient bit per cycle.
//  Reset (aresetn low, synchronous) clears all scan state and the white code;
//  cfg_ready is always high. m_tready low stalls only row ends.
//
module track_edge_and_center_finder_top #(
    parameter int ROW_PIXELS = tecf_pkg::DEF_ROW_PIXELS,
    parameter int FRAME_ROWS = tecf_pkg::DEF_FRAME_ROWS,
    parameter int GROUP_ROWS = tecf_pkg::DEF_GROUP_ROWS,
    parameter int RUN_LENGTH = tecf_pkg::DEF_RUN_LENGTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_byte
    input  logic [0:0]  s_tuser,   // [0] frame_start
    // row result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [5:0] row_number, [13:6] left_edge, [21:14] right_edge,
                                   // [29:22] mid_column, [36:30] row_width,
                                   // [48:37] group_mean_x16, [61:49] track_area,
                                   // [67:62] turn_row, [71:68] zero
    output logic [0:0]  m_tuser,   // [0] group_done
    output logic        m_tlast,   // frame_done
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data   // [0] white_code
);
    import tecf_pkg::*;

    localparam int BYTES_PER_ROW = (ROW_PIXELS + 7) / 8;
    localparam int BP_W  = $clog2(BYTES_PER_ROW);
    localparam int ROW_W = $clog2(FRAME_ROWS);
    localparam int GP_W  = $clog2(GROUP_ROWS + 1);
    localparam int CNT_W = $clog2(GROUP_ROWS + 1);
    localparam int GS_W  = $clog2(GROUP_ROWS * (ROW_PIXELS - 1) + 1);
    localparam int DW    = GS_W + 4;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } state_t;

    // control and scan state
    state_t             state_reg;
    logic               white_code_reg;
    logic [BP_W-1:0]    bp_reg;
    scan_t              scan_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [GP_W-1:0]    gpos_reg;
    logic [GS_W-1:0]    gsum_reg;
    logic [CNT_W-1:0]   gcnt_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [TURN_W-1:0]  egr_reg;
    logic               m_valid_reg;
    logic               m_valid_next;

    // output payload
    logic [ROWNUM_W-1:0] rownum_reg;
    logic [EDGE_W-1:0]   left_reg;
    logic [EDGE_W-1:0]   right_reg;
    logic [EDGE_W-1:0]   mid_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic                gdone_reg;
    logic [MEAN_W-1:0]   gmean_reg;
    logic                fdone_reg;
    logic [AREA_W-1:0]   tarea_reg;
    logic [TURN_W-1:0]   turn_reg;

    // state as seen by this byte, after a frame start clears it
    logic               fs;
    logic [BP_W-1:0]    bp_eff;
    scan_t              scan_eff;
    logic [ROW_W-1:0]   row_eff;
    logic [GP_W-1:0]    gpos_eff;
    logic [GS_W-1:0]    gsum_eff;
    logic [CNT_W-1:0]   gcnt_eff;
    logic [AREA_W-1:0]  area_eff;
    logic [TURN_W-1:0]  egr_eff;

    logic [LANES-1:0]   white_vec;
    lane_res_t          lane_res [LANES];
    scan_t              scan_next;

    logic               s_fire;
    logic               row_end;
    logic [EDGE_W-1:0]  left_edge;
    logic [EDGE_W-1:0]  right_edge;
    logic [EDGE_W:0]    edge_sum;
    logic [EDGE_W-1:0]  mid_col;
    logic [EDGE_W-1:0]  row_w;
    logic               row_ok;
    logic [GS_W-1:0]    gsum_next;
    logic [CNT_W-1:0]   gcnt_next;
    logic [AREA_W-1:0]  area_next;
    logic [TURN_W-1:0]  egr_next;
    logic               gdone;
    logic               fdone;
    logic               need_div;

    logic               div_done;
    logic [DW-1:0]      div_quo;

    assign cfg_ready = 1'b1;

    // Hold the row-ending byte back until the output slot can take its result.
    assign s_tready = (state_reg == S_IDLE)
                   && ((bp_reg != BP_W'(BYTES_PER_ROW - 1)) || !m_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign fs       = s_tuser[0];

    always_comb begin
        bp_eff   = fs ? '0 : bp_reg;
        scan_eff = fs ? SCAN_CLEAR : scan_reg;
        row_eff  = fs ? '0 : row_reg;
        gpos_eff = fs ? '0 : gpos_reg;
        gsum_eff = fs ? '0 : gsum_reg;
        gcnt_eff = fs ? '0 : gcnt_reg;
        area_eff = fs ? '0 : area_reg;
        egr_eff  = fs ? '0 : egr_reg;
    end

    // Lane b takes the pixel in column byte_pos*8 + b, which is bit 7-b.
    for (genvar b = 0; b < LANES; b++) begin : g_lane
        assign white_vec[b] = (s_tdata[LANES-1-b] == white_code_reg);
        tecf_lane #(
            .LANE       (b),
            .ROW_PIXELS (ROW_PIXELS),
            .RUN_LENGTH (RUN_LENGTH),
            .BP_W       (BP_W)
        ) u_lane (
            .white    (white_vec),
            .byte_pos (bp_eff),
            .run_in   (scan_eff.white_run),
            .res      (lane_res[b])
        );
    end

    tecf_merge #(
        .RUN_LENGTH (RUN_LENGTH),
        .BP_W       (BP_W)
    ) u_merge (
        .lane_res (lane_res),
        .byte_pos (bp_eff),
        .scan_in  (scan_eff),
        .scan_out (scan_next)
    );

    // Row, group and frame results for a row-ending byte.
    always_comb begin
        row_end    = (bp_eff == BP_W'(BYTES_PER_ROW - 1));
        left_edge  = scan_next.first_found ? scan_next.first_left : NO_EDGE;
        right_edge = scan_next.first_found ? scan_next.last_right : NO_EDGE;
        edge_sum   = {1'b0, left_edge} + {1'b0, right_edge};
        mid_col    = edge_sum[EDGE_W:1];
        row_w      = right_edge - left_edge;
        row_ok     = (row_w < EDGE_W'(ROW_PIXELS)) && (mid_col < EDGE_W'(ROW_PIXELS));

        gsum_next = row_ok ? (gsum_eff + GS_W'(mid_col)) : gsum_eff;
        gcnt_next = row_ok ? (gcnt_eff + CNT_W'(1)) : gcnt_eff;
        area_next = row_ok ? (area_eff + AREA_W'(row_w)) : area_eff;

        gdone    = (gpos_eff == GP_W'(GROUP_ROWS - 1));
        fdone    = (row_eff == ROW_W'(FRAME_ROWS - 1));
        need_div = gdone && (gcnt_next != '0);
        egr_next = (gdone && (gcnt_next == '0)) ? TURN_W'(row_eff) : egr_eff;
    end

    tecf_div #(
        .DW (DW),
        .VW (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_fire && row_end && need_div),
        .dividend ({gsum_next, 4'b0000}),
        .divisor  (gcnt_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Raise valid when a row result is complete, drop it once the sink takes it.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if ((s_fire && row_end && !need_div) || ((state_reg == S_DIV) && div_done)) begin
            m_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            white_code_reg <= 1'b0;
            bp_reg         <= '0;
            scan_reg       <= SCAN_CLEAR;
            row_reg        <= '0;
            gpos_reg       <= '0;
            gsum_reg       <= '0;
            gcnt_reg       <= '0;
            area_reg       <= '0;
            egr_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                white_code_reg <= cfg_data[0];
            end

            m_valid_reg <= m_valid_next;

            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        if (!row_end) begin
                            // advance within the row
                            bp_reg   <= bp_eff + BP_W'(1);
                            scan_reg <= scan_next;
                            row_reg  <= row_eff;
                            gpos_reg <= gpos_eff;
                            gsum_reg <= gsum_eff;
                            gcnt_reg <= gcnt_eff;
                            area_reg <= area_eff;
                            egr_reg  <= egr_eff;
                        end else begin
                            bp_reg   <= '0;
                            scan_reg <= SCAN_CLEAR;
                            if (fdone) begin
                                row_reg  <= '0;
                                gpos_reg <= '0;
                                gsum_reg <= '0;
                                gcnt_reg <= '0;
                                area_reg <= '0;
                                egr_reg  <= '0;
                            end else begin
                                row_reg  <= row_eff + ROW_W'(1);
                                gpos_reg <= gdone ? '0 : (gpos_eff + GP_W'(1));
                                gsum_reg <= gdone ? '0 : gsum_next;
                                gcnt_reg <= gdone ? '0 : gcnt_next;
                                area_reg <= area_next;
                                egr_reg  <= egr_next;
                            end
                            if (need_div) begin
                                state_reg <= S_DIV;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output payload; the slot is free whenever a row-ending byte is taken
    always_ff @(posedge aclk) begin
        if (s_fire && row_end) begin
            rownum_reg <= ROWNUM_W'(row_eff);
            left_reg   <= left_edge;
            right_reg  <= right_edge;
            mid_reg    <= mid_col;
            width_reg  <= WIDTH_W'(row_w);
            gdone_reg  <= gdone;
            gmean_reg  <= (gdone && !need_div) ? EMPTY_MEAN : '0;
            fdone_reg  <= fdone;
            tarea_reg  <= area_next;
            turn_reg   <= egr_next;
        end else if ((state_reg == S_DIV) && div_done) begin
            gmean_reg <= MEAN_W'(div_quo);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, turn_reg, tarea_reg, gmean_reg, width_reg,
                       mid_reg, right_reg, left_reg, rownum_reg};
    assign m_tuser  = gdone_reg;
    assign m_tlast  = fdone_reg;

endmodule
